// ===== sv/dedc_pkg.sv =====
`default_nettype none

package dedc_pkg;

  localparam int KIND_W  = 6;
  localparam int TIME_W  = 32;
  localparam int HITS_W  = 16;
  localparam int QIDX_W  = 3;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  // request codes
  localparam logic OP_LOG   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] first_seen;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // end of one request, from the scan sequencer to the top level
  typedef struct packed {
    logic   strobe;
    logic   hit;
    logic   new_slot;
    entry_t entry;
  } fin_t;

endpackage

`default_nettype wire

// ===== sv/dedup_error_event_cache_top.sv =====
`default_nettype none

// Error-event cache with one slot per error type, kept as a ring of
// SLOT_COUNT entries in a single RAM. A log or query request is taken when
// start is high and busy is low; its one result shows on hit/entry_* for a
// single cycle with done high and must be captured then, as the receiver
// cannot stall. Requests are scanned one slot per cycle from the newest
// slot back, through the RAM's single read port; logging type zero
// returns an empty result without a scan. A merged log saturates the
// count at 65535.
module dedup_error_event_cache_top import dedc_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              operation,
  input  wire logic [KIND_W-1:0] error_type,
  input  wire logic [TIME_W-1:0] event_time,
  input  wire logic [QIDX_W-1:0] query_index,
  output logic                   done,
  output logic                   hit,
  output logic      [KIND_W-1:0] entry_type,
  output logic      [TIME_W-1:0] entry_time,
  output logic      [HITS_W-1:0] entry_count
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic [IDX_W-1:0]      head;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  entry_t                wr_data;
  entry_t                rd_data;
  fin_t                  fin;

  dedc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  dedc_scan #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .error_type (error_type),
    .event_time (event_time),
    .query_index(query_index),
    .head       (head),
    .slot_valid (slot_valid),
    .rd_data    (rd_data),
    .busy       (busy),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .fin        (fin)
  );

  // empty slots read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      slot_valid <= '0;
      done       <= 1'b0;
    end else begin
      done <= fin.strobe;
      if (fin.new_slot) begin
        slot_valid[head] <= 1'b1;
        head             <= (head == LAST_IDX) ? '0 : head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin.strobe) begin
      hit         <= fin.hit;
      entry_type  <= fin.entry.kind;
      entry_time  <= fin.entry.first_seen;
      entry_count <= fin.entry.hits;
    end
  end

`ifndef SYNTHESIS
  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(operation == OP_LOG && error_type == '0) |=> busy)
    else $error("request with a scan did not hold busy");

  a_hit_has_type: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> entry_type != '0 && entry_count != '0)
    else $error("new or found slot reported without type or count");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    done && entry_type == '0 |-> !hit && entry_time == '0 && entry_count == '0)
    else $error("empty result carries data");

  a_head_moves_on_new: assert property (@(posedge clk) disable iff (rst)
    fin.new_slot |=> head != $past(head) || SLOT_COUNT == 1)
    else $error("ring head did not advance after a new slot");
`endif

endmodule

`default_nettype wire

// ===== sv/dedc_ram.sv =====
`default_nettype none

module dedc_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/dedc_scan.sv =====
`default_nettype none

module dedc_scan import dedc_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          operation,
  input  wire logic [KIND_W-1:0]             error_type,
  input  wire logic [TIME_W-1:0]             event_time,
  input  wire logic [QIDX_W-1:0]             query_index,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] head,
  input  wire logic [SLOT_COUNT-1:0]         slot_valid,
  input  wire entry_t                        rd_data,
  output logic                               busy,
  output logic      [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic                               wr_en,
  output logic      [$clog2(SLOT_COUNT)-1:0] wr_idx,
  output entry_t                             wr_data,
  output fin_t                               fin
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state, state_next;
  logic              op_q;
  logic [KIND_W-1:0] type_q;
  logic [TIME_W-1:0] time_q;
  logic [QIDX_W-1:0] want_q;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  cnt;
  logic              issue_done;
  logic              chk_v;
  logic              chk_last;
  logic [IDX_W-1:0]  chk_idx;
  logic [QIDX_W-1:0] seen;

  logic              accept;
  logic              issue;
  entry_t            entry_c;
  entry_t            merged;
  logic              occupied;
  logic              match;
  logic              exhausted;
  logic [IDX_W-1:0]  start_ptr;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && (state == ST_IDLE);
  assign issue     = (state == ST_SCAN) && !issue_done;
  assign rd_addr   = ptr;
  // newest slot sits just behind the ring head
  assign start_ptr = (head == '0) ? LAST_IDX : head - 1'b1;

  always_comb begin
    entry_c = slot_valid[chk_idx] ? rd_data : '0;
    merged  = entry_c;
    if (entry_c.hits != HITS_MAX) begin
      merged.hits = entry_c.hits + 1'b1;
    end
    occupied = (entry_c.kind != '0);
    if (op_q == OP_LOG) begin
      match = chk_v && (entry_c.kind == type_q);
    end else begin
      match = chk_v && occupied && (seen == want_q);
    end
    exhausted = chk_v && chk_last && !match;
  end

  always_comb begin
    state_next = state;
    fin        = '0;
    wr_en      = 1'b0;
    wr_idx     = chk_idx;
    wr_data    = merged;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // logging type zero is dropped with an empty result
          if (operation == OP_LOG && error_type == '0) begin
            fin.strobe = 1'b1;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_IDLE;
          fin.strobe = 1'b1;
          if (op_q == OP_LOG) begin
            wr_en     = 1'b1;
            fin.entry = merged;
          end else begin
            fin.hit   = 1'b1;
            fin.entry = entry_c;
          end
        end else if (exhausted) begin
          state_next = ST_IDLE;
          fin.strobe = 1'b1;
          if (op_q == OP_LOG) begin
            wr_en                = 1'b1;
            wr_idx               = head;
            wr_data.kind         = type_q;
            wr_data.first_seen   = time_q;
            wr_data.hits         = HITS_W'(1);
            fin.hit              = 1'b1;
            fin.new_slot         = 1'b1;
            fin.entry            = wr_data;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chk_v <= 1'b0;
    end else begin
      state <= state_next;
      chk_v <= issue && (state_next == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      type_q     <= error_type;
      time_q     <= event_time;
      want_q     <= query_index;
      ptr        <= start_ptr;
      cnt        <= '0;
      issue_done <= 1'b0;
      seen       <= '0;
    end else begin
      if (issue) begin
        ptr        <= (ptr == '0) ? LAST_IDX : ptr - 1'b1;
        cnt        <= cnt + 1'b1;
        issue_done <= (cnt == LAST_IDX);
        chk_idx    <= ptr;
        chk_last   <= (cnt == LAST_IDX);
      end
      if (chk_v && op_q == OP_QUERY && occupied && !match) begin
        seen <= seen + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/dedup_error_event_cache_checker.sv =====
`default_nettype none

module dedup_error_event_cache_checker import dedc_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic              operation,
  input  wire logic [KIND_W-1:0] error_type,
  input  wire logic [TIME_W-1:0] event_time,
  input  wire logic [QIDX_W-1:0] query_index,
  input  wire logic              done,
  input  wire logic              hit,
  input  wire logic [KIND_W-1:0] entry_type,
  input  wire logic [TIME_W-1:0] entry_time,
  input  wire logic [HITS_W-1:0] entry_count,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic   hit;
    entry_t entry;
  } lookup_t;

  entry_t      slot_q [SLOT_COUNT];
  int unsigned ring_pos;
  lookup_t     due_lookups [$];
  int          mismatches;

  function automatic void clear_cache();
    for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] = '0;
    ring_pos = 0;
  endfunction

  // applies one request to the shadow cache and returns the result it gives
  function automatic lookup_t cache_access(logic op, logic [KIND_W-1:0] etype,
                                           logic [TIME_W-1:0] stamp,
                                           logic [QIDX_W-1:0] want);
    lookup_t     res;
    bit          found;
    int unsigned seen;
    int unsigned j;
    res   = '0;
    found = 1'b0;
    seen  = 0;
    if (op == OP_LOG) begin
      if (etype != '0) begin
        for (int i = 0; i < SLOT_COUNT && !found; i++) begin
          if (slot_q[i].kind == etype) begin
            if (slot_q[i].hits != HITS_MAX) slot_q[i].hits = slot_q[i].hits + 1'b1;
            res.hit   = 1'b0;
            res.entry = slot_q[i];
            found     = 1'b1;
          end
        end
        if (!found) begin
          slot_q[ring_pos].kind       = etype;
          slot_q[ring_pos].first_seen = stamp;
          slot_q[ring_pos].hits       = HITS_W'(1);
          res.hit   = 1'b1;
          res.entry = slot_q[ring_pos];
          ring_pos  = (ring_pos + 1 == SLOT_COUNT) ? 0 : ring_pos + 1;
        end
      end
    end else begin
      // newest first, empty slots skipped
      for (int i = 0; i < SLOT_COUNT && !found; i++) begin
        j = (ring_pos + SLOT_COUNT - 1 - i) % SLOT_COUNT;
        if (slot_q[j].kind != '0) begin
          if (seen == want) begin
            res.hit   = 1'b1;
            res.entry = slot_q[j];
            found     = 1'b1;
          end
          seen++;
        end
      end
    end
    return res;
  endfunction

  initial begin
    clear_cache();
    mismatches = 0;
  end

  always @(posedge clk) begin
    lookup_t want_res;
    if (rst) begin
      clear_cache();
      due_lookups.delete();
    end else begin
      if (done) begin
        if (due_lookups.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with none due: hit=%0d type=%0d time=%0h count=%0d",
                     $realtime, hit, entry_type, entry_time, entry_count);
          mismatches++;
        end else begin
          want_res = due_lookups.pop_front();
          if (hit !== want_res.hit || entry_type !== want_res.entry.kind ||
              entry_time !== want_res.entry.first_seen ||
              entry_count !== want_res.entry.hits) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp hit=%0d type=%0d time=%0h count=%0d, got hit=%0d type=%0d time=%0h count=%0d",
                       $realtime, want_res.hit, want_res.entry.kind,
                       want_res.entry.first_seen, want_res.entry.hits,
                       hit, entry_type, entry_time, entry_count);
            mismatches++;
          end
        end
      end
      // request transfer
      if (start && !busy)
        due_lookups.push_back(cache_access(operation, error_type, event_time, query_index));
    end
    fail_count <= mismatches;
    pending    <= due_lookups.size();
  end

endmodule

`default_nettype wire

// ===== bench/dedup_error_event_cache_top_tb.sv =====
`default_nettype none

module dedup_error_event_cache_top_tb import dedc_pkg::*;;

  localparam int SLOT_COUNT    = 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int TAIL_CYCLES   = SLOT_COUNT + 6;
  localparam int RANDOM_REQS   = 1000;
  localparam int MERGE_REPEATS = 24;

  logic              clk;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic              operation   = OP_LOG;
  logic [KIND_W-1:0] error_type  = '0;
  logic [TIME_W-1:0] event_time  = '0;
  logic [QIDX_W-1:0] query_index = '0;
  logic              busy;
  logic              done;
  logic              hit;
  logic [KIND_W-1:0] entry_type;
  logic [TIME_W-1:0] entry_time;
  logic [HITS_W-1:0] entry_count;

  int fail_count;
  int pending;
  int cycles = 0;

  dedup_error_event_cache_top #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .error_type  (error_type),
    .event_time  (event_time),
    .query_index (query_index),
    .done        (done),
    .hit         (hit),
    .entry_type  (entry_type),
    .entry_time  (entry_time),
    .entry_count (entry_count)
  );

  dedup_error_event_cache_checker #(.SLOT_COUNT(SLOT_COUNT)) cache_monitor (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .error_type  (error_type),
    .event_time  (event_time),
    .query_index (query_index),
    .done        (done),
    .hit         (hit),
    .entry_type  (entry_type),
    .entry_time  (entry_time),
    .entry_count (entry_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // holds the request until the block is idle; start drops only for a gap
  task automatic issue(logic op, logic [KIND_W-1:0] etype, logic [TIME_W-1:0] stamp,
                       logic [QIDX_W-1:0] idx, bit paced);
    int gap;
    start       <= 1'b1;
    operation   <= op;
    error_type  <= etype;
    event_time  <= stamp;
    query_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = paced ? pick_gap() : 0;
    if (gap > 0) begin
      // junk on the fields while idle
      start       <= 1'b0;
      operation   <= 1'($urandom());
      error_type  <= KIND_W'($urandom());
      event_time  <= $urandom();
      query_index <= QIDX_W'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int               counted;
    int               r;
    logic             op;
    logic [KIND_W-1:0] etype;
    logic [TIME_W-1:0] stamp;
    bit               paced;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty cache, ignored type zero, first logs with a merge, and queries
    issue(OP_QUERY, '0, '0, 3'd0, 1'b1);
    issue(OP_QUERY, '1, '1, 3'd7, 1'b1);
    issue(OP_LOG, '0, '1, 3'd7, 1'b1);
    issue(OP_LOG, 6'd1, '0, 3'd5, 1'b1);
    issue(OP_LOG, 6'd63, '1, 3'd0, 1'b1);
    issue(OP_LOG, 6'd1, 32'h1234_5678, 3'd7, 1'b1);
    issue(OP_QUERY, 6'd1, '1, 3'd0, 1'b1);
    issue(OP_QUERY, 6'd63, '0, 3'd1, 1'b1);
    issue(OP_QUERY, '0, '0, 3'd2, 1'b1);
    // fill the ring, then evict
    for (int k = 2; k <= 7; k++) issue(OP_LOG, KIND_W'(k), $urandom(), 3'd0, 1'b1);
    issue(OP_LOG, 6'd8, 32'h8000_0000, 3'd3, 1'b1);
    issue(OP_QUERY, '0, '0, 3'd7, 1'b1);
    issue(OP_LOG, 6'd1, 32'h0000_0001, 3'd1, 1'b1);
    issue(OP_LOG, '0, '0, '1, 1'b1);

    // repeated merges into one slot, back to back
    for (int k = 0; k < MERGE_REPEATS; k++)
      issue(OP_LOG, 6'd9, $urandom(), QIDX_W'(k), 1'b0);
    for (int k = 0; k < SLOT_COUNT; k++)
      issue(OP_QUERY, KIND_W'($urandom()), $urandom(), QIDX_W'(k), 1'b1);

    counted = 0;
    while (counted < RANDOM_REQS) begin
      op = ($urandom_range(0, 99) < 30) ? OP_QUERY : OP_LOG;
      r  = $urandom_range(0, 99);
      // a pool a little larger than the ring gives both merges and evictions
      if (r < 5)       etype = '0;
      else if (r < 75) etype = KIND_W'($urandom_range(1, 12));
      else             etype = KIND_W'($urandom_range(0, 63));
      r = $urandom_range(0, 19);
      if (r == 0)      stamp = '0;
      else if (r == 1) stamp = '1;
      else             stamp = $urandom();
      paced = !(counted >= 400 && counted < 500);
      issue(op, etype, stamp, QIDX_W'($urandom_range(0, 7)), paced);
      if (!(op == OP_LOG && etype == '0)) counted++;
    end
    // last request leaves the inputs alone, so start drops here only
    issue(OP_QUERY, '0, '0, 3'd0, 1'b0);
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
